// ----- hw/rtl/sss_pkg.sv -----
`default_nettype none
package sss_pkg;

  localparam int ACT_BITS = 3;
  localparam int IDX_BITS = 4;
  localparam int OUT_VALUE_BITS = 32;
  localparam int OUT_CNT_BITS = 5;
  localparam int ST_BITS = 2;

  localparam logic [ACT_BITS-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_DELETE = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_READ   = 3'd4;

  typedef logic [2:0] op_t;

  localparam op_t OP_NOP = 3'd0;
  localparam op_t OP_CLR = 3'd1;
  localparam op_t OP_APP = 3'd2;
  localparam op_t OP_INS = 3'd3;
  localparam op_t OP_DEL = 3'd4;
  localparam op_t OP_RD  = 3'd5;

  localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [ST_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_BITS-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sss_cell.sv -----
`default_nettype none
module sss_cell #(
  parameter int VALUE_BITS = 32,
  parameter int CNT_BITS = 5,
  parameter int INDEX = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sss_pkg::op_t                   op_i,
  input  wire logic signed [VALUE_BITS-1:0]   val_i,
  input  wire logic [CNT_BITS-1:0]            cnt_i,
  input  wire logic [sss_pkg::IDX_BITS-1:0]   idx_i,
  input  wire sss_pkg::tok_t                  tok_i,
  input  wire logic signed [VALUE_BITS-1:0]   carry_i,
  input  wire logic signed [VALUE_BITS-1:0]   right_i,
  output sss_pkg::tok_t                       tok_o,
  output logic signed [VALUE_BITS-1:0]        carry_o,
  output logic signed [VALUE_BITS-1:0]        value_o
);

  localparam logic [CNT_BITS-1:0] POS = CNT_BITS'(INDEX);

  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic signed [VALUE_BITS-1:0] carry_r, carry_nxt;
  sss_pkg::tok_t                tok_r, tok_nxt;
  logic                         below_cnt, at_cnt, idx_hit;

  assign below_cnt = POS < cnt_i;
  assign at_cnt    = POS == cnt_i;
  assign idx_hit   = 32'(idx_i) == 32'(INDEX);

  always_comb begin
    val_nxt   = val_r;
    carry_nxt = carry_i;
    tok_nxt   = tok_i;
    if (tok_i.valid) begin
      case (op_i)
        sss_pkg::OP_INS: begin
          if (below_cnt) begin
            if (tok_i.found) begin
              val_nxt   = carry_i;
              carry_nxt = val_r;
            end else if (val_r > val_i) begin
              val_nxt       = val_i;
              carry_nxt     = val_r;
              tok_nxt.found = 1'b1;
            end
          end else if (at_cnt) begin
            val_nxt = tok_i.found ? carry_i : val_i;
          end
        end
        sss_pkg::OP_APP: begin
          if (at_cnt) begin
            val_nxt = val_i;
          end
        end
        sss_pkg::OP_DEL: begin
          if (below_cnt && (tok_i.found || val_r[VALUE_BITS-1])) begin
            val_nxt       = right_i;
            tok_nxt.found = 1'b1;
          end
        end
        sss_pkg::OP_RD: begin
          if (below_cnt && idx_hit) begin
            carry_nxt     = val_r;
            tok_nxt.found = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    carry_r <= carry_nxt;
  end

  assign tok_o   = tok_r;
  assign carry_o = carry_r;
  assign value_o = val_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_sequence_store.sv -----
`default_nettype none
// Sorted sequence store: a bounded list of signed values kept in a row of
// DEPTH cells. Each input item (action, item_value, read_index) yields one
// result item (read_value, element_count, status) on the out_ channel.
// Both channels use valid/stall; an item moves on a clock edge with valid
// high and stall low.
// Every action sends one token down the cell row, one cell per cycle; each
// cell shifts, inserts, removes or reports its value as the token passes.
// Every action takes the same path: token register, DEPTH cells, then the
// output or hold register. One item is in the row at a time; in_stall is
// high while a token is in the row, so the next item waits for it to leave.
// A finished result waits in the output register; a second one waits in a
// hold register, so the next item is taken while a result sits unclaimed.
// in_stall also stays high while the hold register is full.
// Reset (rst_n low, synchronous) empties the store and drops any result in
// flight. Stored values are not cleared; only entries below the count are
// ever read.
module sorted_sequence_store #(
  parameter int DEPTH = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic [sss_pkg::ACT_BITS-1:0]             in_action,
  input  wire logic signed [sss_pkg::OUT_VALUE_BITS-1:0] in_item_value,
  input  wire logic [sss_pkg::IDX_BITS-1:0]             in_read_index,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic signed [sss_pkg::OUT_VALUE_BITS-1:0]     out_read_value,
  output logic [sss_pkg::OUT_CNT_BITS-1:0]              out_element_count,
  output logic [sss_pkg::ST_BITS-1:0]                   out_status
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic                         in_acc, out_acc;
  logic                         busy_r, busy_nxt;
  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt;
  sss_pkg::op_t                 op_r, op_nxt;
  logic [sss_pkg::ST_BITS-1:0]  pre_st_r, pre_st_nxt;
  logic signed [VALUE_BITS-1:0] val_r;
  logic [sss_pkg::IDX_BITS-1:0] idx_r;
  sss_pkg::tok_t                tok0_r, tok0_nxt;
  logic signed [63:0]           in_ext;
  logic signed [63:0]           rd_ext;
  logic [31:0]                  cnt_ext;

  sss_pkg::tok_t                tok_link [DEPTH+1];
  logic signed [VALUE_BITS-1:0] carry_link [DEPTH+1];
  logic signed [VALUE_BITS-1:0] cell_val [DEPTH];

  logic [sss_pkg::OUT_VALUE_BITS-1:0] res_rd;
  logic [sss_pkg::ST_BITS-1:0]        res_st;
  logic                               end_v;

  logic                               out_valid_r, out_valid_nxt;
  logic                               hold_v_r, hold_v_nxt;
  logic [sss_pkg::OUT_VALUE_BITS-1:0] out_rd_r, out_rd_nxt, hold_rd_r, hold_rd_nxt;
  logic [sss_pkg::OUT_CNT_BITS-1:0]   out_cnt_r, out_cnt_nxt, hold_cnt_r, hold_cnt_nxt;
  logic [sss_pkg::ST_BITS-1:0]        out_st_r, out_st_nxt, hold_st_r, hold_st_nxt;

  assign in_stall = busy_r || hold_v_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_ext   = 64'(in_item_value);

  // decode the action against the current count
  always_comb begin
    op_nxt     = op_r;
    pre_st_nxt = pre_st_r;
    tok0_nxt   = '0;
    if (in_acc) begin
      tok0_nxt.valid = 1'b1;
      pre_st_nxt     = sss_pkg::ST_OK;
      case (in_action)
        sss_pkg::ACT_CLEAR: op_nxt = sss_pkg::OP_CLR;
        sss_pkg::ACT_APPEND: begin
          if (cnt_r == FULL_CNT) begin
            op_nxt     = sss_pkg::OP_NOP;
            pre_st_nxt = sss_pkg::ST_FULL;
          end else begin
            op_nxt = sss_pkg::OP_APP;
          end
        end
        sss_pkg::ACT_INSERT: begin
          if (cnt_r == '0) begin
            op_nxt     = sss_pkg::OP_NOP;
            pre_st_nxt = sss_pkg::ST_EMPTY;
          end else if (cnt_r == FULL_CNT) begin
            op_nxt     = sss_pkg::OP_NOP;
            pre_st_nxt = sss_pkg::ST_FULL;
          end else begin
            op_nxt = sss_pkg::OP_INS;
          end
        end
        sss_pkg::ACT_DELETE: op_nxt = sss_pkg::OP_DEL;
        sss_pkg::ACT_READ:   op_nxt = sss_pkg::OP_RD;
        default:             op_nxt = sss_pkg::OP_NOP;
      endcase
    end
  end

  assign tok_link[0]   = tok0_r;
  assign carry_link[0] = val_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] right_val;
    if (i < DEPTH - 1) begin : g_mid
      assign right_val = cell_val[i+1];
    end else begin : g_last
      assign right_val = cell_val[i];
    end
    sss_cell #(
      .VALUE_BITS(VALUE_BITS),
      .CNT_BITS(CNT_BITS),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .op_i(op_r),
      .val_i(val_r),
      .cnt_i(cnt_r),
      .idx_i(idx_r),
      .tok_i(tok_link[i]),
      .carry_i(carry_link[i]),
      .right_i(right_val),
      .tok_o(tok_link[i+1]),
      .carry_o(carry_link[i+1]),
      .value_o(cell_val[i])
    );
  end

  assign end_v  = tok_link[DEPTH].valid;
  assign rd_ext = 64'(carry_link[DEPTH]);

  // result when the token leaves the last cell
  always_comb begin
    cnt_nxt = cnt_r;
    res_rd  = '0;
    res_st  = pre_st_r;
    if (end_v) begin
      case (op_r)
        sss_pkg::OP_CLR: cnt_nxt = '0;
        sss_pkg::OP_APP, sss_pkg::OP_INS: cnt_nxt = cnt_r + 1'b1;
        sss_pkg::OP_DEL: begin
          if (tok_link[DEPTH].found) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            res_st = sss_pkg::ST_EMPTY;
          end
        end
        sss_pkg::OP_RD: begin
          if (tok_link[DEPTH].found) begin
            res_rd = rd_ext[sss_pkg::OUT_VALUE_BITS-1:0];
          end else begin
            res_st = sss_pkg::ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_ext  = 32'(cnt_nxt);
  assign busy_nxt = in_acc ? 1'b1 : (end_v ? 1'b0 : busy_r);

  // output register plus one hold slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    hold_v_nxt    = hold_v_r;
    hold_rd_nxt   = hold_rd_r;
    hold_cnt_nxt  = hold_cnt_r;
    hold_st_nxt   = hold_st_r;
    if (out_acc) begin
      out_valid_nxt = hold_v_r;
      out_rd_nxt    = hold_rd_r;
      out_cnt_nxt   = hold_cnt_r;
      out_st_nxt    = hold_st_r;
      hold_v_nxt    = 1'b0;
    end
    if (end_v) begin
      if (!out_valid_r || out_acc) begin
        out_valid_nxt = 1'b1;
        out_rd_nxt    = res_rd;
        out_cnt_nxt   = cnt_ext[sss_pkg::OUT_CNT_BITS-1:0];
        out_st_nxt    = res_st;
      end else begin
        hold_v_nxt   = 1'b1;
        hold_rd_nxt  = res_rd;
        hold_cnt_nxt = cnt_ext[sss_pkg::OUT_CNT_BITS-1:0];
        hold_st_nxt  = res_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      op_r        <= sss_pkg::OP_NOP;
      pre_st_r    <= sss_pkg::ST_OK;
      tok0_r      <= '0;
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      pre_st_r    <= pre_st_nxt;
      tok0_r      <= tok0_nxt;
      out_valid_r <= out_valid_nxt;
      hold_v_r    <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_r <= in_ext[VALUE_BITS-1:0];
      idx_r <= in_read_index;
    end
    out_rd_r   <= out_rd_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_st_r   <= out_st_nxt;
    hold_rd_r  <= hold_rd_nxt;
    hold_cnt_r <= hold_cnt_nxt;
    hold_st_r  <= hold_st_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_rd_r;
  assign out_element_count = out_cnt_r;
  assign out_status        = out_st_r;

`ifndef ASSERT_OFF
  a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> out_valid_r)
    else $error("hold slot full while output register empty");

  a_no_busy_with_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && hold_v_r))
    else $error("token in row while hold slot full");

  a_end_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    end_v |-> busy_r)
    else $error("token left the row with no item in flight");

  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (tok0_r.valid && busy_r))
    else $error("accepted item did not launch a token");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(DEPTH))
    else $error("element count above depth");
`endif

endmodule
`default_nettype wire

// ----- dv/sorted_sequence_store_test.sv -----
module sorted_sequence_store_test;

  localparam int STORE_DEPTH = 16;
  localparam int ITEM_GOAL = 1600;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = STORE_DEPTH + 24;

  typedef logic signed [sss_pkg::OUT_VALUE_BITS-1:0] value_t;
  typedef logic [sss_pkg::ACT_BITS-1:0]              act_t;
  typedef logic [sss_pkg::IDX_BITS-1:0]              idx_t;
  typedef logic [sss_pkg::OUT_CNT_BITS-1:0]          cnt_t;
  typedef logic [sss_pkg::ST_BITS-1:0]               st_t;

  localparam act_t ACT_SPARE_LO = 3'd5;
  localparam act_t ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    value_t read_value;
    cnt_t   count;
    st_t    status;
  } store_result_t;

  class store_scoreboard;
    value_t        cells[STORE_DEPTH];
    int unsigned   fill;
    store_result_t expected_q[$];
    int            errors;
    int            checked;
    int            status_seen[4];

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_item(act_t act, value_t val, idx_t idx);
      store_result_t res;
      int unsigned   pos;
      bit            found;
      res.read_value = '0;
      res.status = sss_pkg::ST_OK;
      pos = fill;
      found = 1'b0;
      case (act)
        sss_pkg::ACT_CLEAR: fill = 0;
        sss_pkg::ACT_APPEND: begin
          if (fill >= STORE_DEPTH) begin
            res.status = sss_pkg::ST_FULL;
          end else begin
            cells[fill] = val;
            fill++;
          end
        end
        sss_pkg::ACT_INSERT: begin
          if (fill == 0) begin
            res.status = sss_pkg::ST_EMPTY;
          end else if (fill >= STORE_DEPTH) begin
            res.status = sss_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < fill; i++) begin
              if (!found && cells[i] > val) begin
                pos = i;
                found = 1'b1;
              end
            end
            for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            fill++;
          end
        end
        sss_pkg::ACT_DELETE: begin
          for (int i = 0; i < fill; i++) begin
            if (!found && cells[i][sss_pkg::OUT_VALUE_BITS-1]) begin
              pos = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            res.status = sss_pkg::ST_EMPTY;
          end else begin
            for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        sss_pkg::ACT_READ: begin
          if (idx >= fill) res.status = sss_pkg::ST_RANGE;
          else res.read_value = cells[idx];
        end
        default: ;
      endcase
      res.count = fill[sss_pkg::OUT_CNT_BITS-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(value_t rv, cnt_t cnt, st_t st);
      store_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: read_value %0d count %0d status %0d",
               rv, cnt, st);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      checked++;
      if (rv !== exp_res.read_value) begin
        $error("read_value: expected %0d, actual %0d", exp_res.read_value, rv);
        errors++;
      end
      if (cnt !== exp_res.count) begin
        $error("element_count: expected %0d, actual %0d", exp_res.count, cnt);
        errors++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, st);
        errors++;
      end
      status_seen[exp_res.status]++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  act_t   in_action = '0;
  value_t in_item_value = '0;
  idx_t   in_read_index = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t out_read_value;
  cnt_t   out_element_count;
  st_t    out_status;

  store_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  sorted_sequence_store #(
    .DEPTH(STORE_DEPTH),
    .VALUE_BITS(sss_pkg::OUT_VALUE_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_item_value(in_item_value),
    .in_read_index(in_read_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_value(out_read_value),
    .out_element_count(out_element_count),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_read_value, out_element_count, out_status);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_item(input act_t act, input value_t val, input idx_t idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_item_value <= val;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(act, val, idx);
    if (act <= sss_pkg::ACT_READ) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic value_t pick_value();
    int v;
    case ($urandom_range(0, 9))
      0: return {1'b1, {(sss_pkg::OUT_VALUE_BITS-1){1'b0}}};
      1: return {1'b0, {(sss_pkg::OUT_VALUE_BITS-1){1'b1}}};
      2, 3, 4, 5: begin
        v = $urandom_range(0, 40);
        return v - 20;
      end
      6: return $urandom_range(0, 1) ? '0 : '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic act_t pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return sss_pkg::ACT_APPEND;
    if (r < 50) return sss_pkg::ACT_INSERT;
    if (r < 70) return sss_pkg::ACT_DELETE;
    if (r < 95) return sss_pkg::ACT_READ;
    if (r < 98) return sss_pkg::ACT_CLEAR;
    return logic'($urandom_range(0, 1)) ? ACT_SPARE_LO : ACT_SPARE_HI;
  endfunction

  // clear, load to full and past it, then read and delete
  task automatic run_fill_sequence();
    int extra;
    send_item(sss_pkg::ACT_CLEAR, $urandom, idx_t'($urandom));
    send_item(sss_pkg::ACT_APPEND, pick_value(), idx_t'($urandom));
    for (int i = 1; i < STORE_DEPTH; i++)
      send_item($urandom_range(0, 2) ? sss_pkg::ACT_INSERT : sss_pkg::ACT_APPEND,
                pick_value(), idx_t'($urandom));
    extra = $urandom_range(1, 3);
    repeat (extra)
      send_item($urandom_range(0, 1) ? sss_pkg::ACT_INSERT : sss_pkg::ACT_APPEND,
                pick_value(), idx_t'($urandom));
    repeat ($urandom_range(2, 8)) begin
      send_item(sss_pkg::ACT_READ, pick_value(), idx_t'($urandom));
      if ($urandom_range(0, 2) == 0)
        send_item(sss_pkg::ACT_DELETE, pick_value(), idx_t'($urandom));
    end
  endtask

  task automatic run_mixed_sequence();
    repeat ($urandom_range(10, 30)) send_item(pick_action(), pick_value(), idx_t'($urandom));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(3, 10)) send_item(act_t'($urandom), $urandom, idx_t'($urandom));
  endtask

  initial begin
    int pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, extremes, ordering, deletes, spare codes
    send_item(sss_pkg::ACT_READ, '0, '0);
    send_item(sss_pkg::ACT_DELETE, '0, '0);
    send_item(sss_pkg::ACT_INSERT, 32'sd5, '0);
    send_item(sss_pkg::ACT_APPEND, '0, '1);
    send_item(sss_pkg::ACT_INSERT, {1'b1, {(sss_pkg::OUT_VALUE_BITS-1){1'b0}}}, '0);
    send_item(sss_pkg::ACT_INSERT, {1'b0, {(sss_pkg::OUT_VALUE_BITS-1){1'b1}}}, '0);
    send_item(sss_pkg::ACT_INSERT, '0, '0);
    send_item(sss_pkg::ACT_READ, '0, 4'd0);
    send_item(sss_pkg::ACT_READ, '0, 4'd3);
    send_item(sss_pkg::ACT_READ, '0, 4'd15);
    send_item(sss_pkg::ACT_DELETE, '0, '0);
    send_item(sss_pkg::ACT_DELETE, '0, '0);
    send_item(sss_pkg::ACT_READ, '1, 4'd1);
    send_item(ACT_SPARE_LO, '1, '1);
    send_item(ACT_SPARE_HI, '1, '1);
    send_item(sss_pkg::ACT_CLEAR, '1, '1);
    send_item(sss_pkg::ACT_APPEND, -32'sd5, '0);
    send_item(sss_pkg::ACT_DELETE, '0, '0);
    send_item(sss_pkg::ACT_READ, '0, 4'd0);

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = HOLD_OFF_CYCLES;
        end
      endcase
      while (items_sent < (ph + 1) * ITEM_GOAL / 3) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) run_fill_sequence();
        else if (pick < 85) run_mixed_sequence();
        else run_noise();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d items sent, %0d results checked across three idle mixes and a long hold-off",
             items_sent, board.checked);
    $display("status mix: ok %0d, full %0d, empty/none %0d, out of range %0d",
             board.status_seen[sss_pkg::ST_OK], board.status_seen[sss_pkg::ST_FULL],
             board.status_seen[sss_pkg::ST_EMPTY], board.status_seen[sss_pkg::ST_RANGE]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
